// ----- hdl/line_sensor_bang_bang_steering_defines.svh -----
// Assertion macros for the line sensor steering block.
`ifndef LINE_SENSOR_BANG_BANG_STEERING_DEFINES_SVH
`define LINE_SENSOR_BANG_BANG_STEERING_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LSBB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define LSBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/lsbb_pkg.sv -----
// Shared types and constants for the line sensor steering block.
package lsbb_pkg;

   // Field widths
   localparam int SAMPLE_BITS = 10;
   localparam int POWER_BITS  = 8;
   localparam int THRESH_BITS = 11;
   localparam int DIFF_BITS   = 12;
   localparam int SUM_BITS    = 18;

   // Parameter defaults
   localparam int CAL_SAMPLES_DEFAULT = 255;
   localparam int SENSOR_BITS_DEFAULT = 10;

   // Register reset values
   localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET      = 11'd10;
   localparam logic [POWER_BITS-1:0]  STRAIGHT_POWER_RESET = 8'd60;
   localparam logic [POWER_BITS-1:0]  TURN_POWER_RESET     = 8'd80;
   localparam logic [POWER_BITS-1:0]  STOP_POWER_RESET     = 8'd0;

   // Register file port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_THRESHOLD      = 2'd0,
      REG_STRAIGHT_POWER = 2'd1,
      REG_TURN_POWER     = 2'd2,
      REG_STOP_POWER     = 2'd3
   } reg_index_type;

   // Request kind
   localparam logic MODE_CAL = 1'b0;
   localparam logic MODE_RUN = 1'b1;

   // Division by five of a 14-bit magnitude: (a * 26215) >> 17 is exact
   localparam int SMOOTH_MAG_BITS   = 14;
   localparam int SMOOTH_MAGIC_BITS = 15;
   localparam int SMOOTH_SHIFT      = 17;
   localparam logic [SMOOTH_MAGIC_BITS-1:0] SMOOTH_MAGIC = 15'd26215;

   typedef struct packed {
      logic [THRESH_BITS-1:0] threshold;
      logic [POWER_BITS-1:0]  straight_power;
      logic [POWER_BITS-1:0]  turn_power;
      logic [POWER_BITS-1:0]  stop_power;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] left;
      logic [SAMPLE_BITS-1:0] right;
   } baseline_type;

endpackage

// ----- hdl/line_sensor_bang_bang_steering.sv -----
// Response path: an accepted request passes the input register, then the result register.
// Throughput: one request per cycle while responses are taken; a request is still taken while one
// response waits and the input register is free.
// Reset: synchronous, active high; clears sums, count, baselines, smoothing state,
// valid flags, and returns the registers to threshold 10, powers 60 / 80 / 0.
// Line sensor bang-bang steering top level.
`include "line_sensor_bang_bang_steering_defines.svh"

module line_sensor_bang_bang_steering #(
   parameter int CAL_SAMPLES = lsbb_pkg::CAL_SAMPLES_DEFAULT,
   parameter int SENSOR_BITS = lsbb_pkg::SENSOR_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [23:0]                          req_tdata,  // left_sample, right_sample, pad
   input  logic                                 req_tuser,  // req_type
   // Response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [39:0]                          rsp_tdata,  // left_power, right_power,
                                                            // difference, smoothed_difference
   output logic                                 rsp_tuser,  // calibration_done
   // Configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lsbb_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [lsbb_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lsbb_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int SB = lsbb_pkg::SAMPLE_BITS;
   localparam logic [SB-1:0] SampleMask =
      (SENSOR_BITS >= SB) ? {SB{1'b1}} : SB'((1 << SENSOR_BITS) - 1);

   lsbb_pkg::cfg_type       cfg;
   lsbb_pkg::baseline_type  baseline;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_mode_ff;
   logic [SB-1:0]           s1_left_ff, s1_right_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [39:0]             rsp_data_ff;
   logic                    rsp_done_ff;
   logic                    out_free, adv, req_fire, cal_done;

   logic [lsbb_pkg::POWER_BITS-1:0]        left_power, right_power;
   logic signed [lsbb_pkg::DIFF_BITS-1:0]  difference, smoothed_difference;

   // Response fields seen by the checks
   logic [lsbb_pkg::POWER_BITS-1:0]        rsp_left_power, rsp_right_power;
   logic                                   cal_rsp, cal_zero, turning, turn_pair_ok;
   logic                                   stalled_full;

   lsbb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Pipeline handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign adv        = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_mode_ff  <= req_tuser;
         s1_left_ff  <= req_tdata[SB-1:0] & SampleMask;
         s1_right_ff <= req_tdata[2*SB-1:SB] & SampleMask;
      end
   end

   lsbb_cal #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_cal (
      .clock    (clock),
      .reset    (reset),
      .fire     (adv),
      .mode     (s1_mode_ff),
      .left     (s1_left_ff),
      .right    (s1_right_ff),
      .baseline (baseline),
      .done     (cal_done)
   );

   lsbb_run u_run (
      .clock               (clock),
      .reset               (reset),
      .fire                (adv),
      .mode                (s1_mode_ff),
      .left                (s1_left_ff),
      .right               (s1_right_ff),
      .baseline            (baseline),
      .cfg                 (cfg),
      .left_power          (left_power),
      .right_power         (right_power),
      .difference          (difference),
      .smoothed_difference (smoothed_difference)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         rsp_data_ff <= {smoothed_difference, difference, right_power, left_power};
         rsp_done_ff <= cal_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_done_ff;

   // Terms for the checks below
   assign rsp_left_power  = rsp_tdata[7:0];
   assign rsp_right_power = rsp_tdata[15:8];
   assign cal_rsp         = rsp_tvalid && rsp_tuser;
   assign cal_zero        = (rsp_tdata[27:0] == 28'd0);
   assign turning         = rsp_tvalid && (rsp_left_power != rsp_right_power);
   assign turn_pair_ok    =
      ((rsp_left_power == cfg.stop_power) && (rsp_right_power == cfg.turn_power)) ||
      ((rsp_left_power == cfg.turn_power) && (rsp_right_power == cfg.stop_power));
   assign stalled_full    = s1_valid_ff && rsp_tvalid && !rsp_tready;

   // A calibration response carries zero powers and zero difference
   `LSBB_ASSERT_NOW(a_cal_zero, clock, reset, cal_rsp, cal_zero, "calibration response not zero")

   // Unequal powers only ever come as a stop / turn pair
   `LSBB_ASSERT_NOW(a_turn_pair, clock, reset, turning, turn_pair_ok, "turn powers mismatch")

   // A full pipeline with a stalled response takes no new request
   `LSBB_ASSERT_NOW(a_full_stall, clock, reset, stalled_full, !req_tready, "accepted while full")

   // An advancing item always shows up as a valid response next cycle
   `LSBB_ASSERT_NEXT(a_adv_out, clock, reset, adv, rsp_tvalid, "advanced item lost")

endmodule

// ----- hdl/lsbb_csr.sv -----
// Configuration registers with an APB-style access port.
module lsbb_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lsbb_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [lsbb_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lsbb_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output lsbb_pkg::cfg_type                    cfg
);

   lsbb_pkg::cfg_type       cfg_ff, cfg_in;
   lsbb_pkg::reg_index_type index;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign index      = lsbb_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            lsbb_pkg::REG_THRESHOLD:
               cfg_in.threshold = csr_pwdata[lsbb_pkg::THRESH_BITS-1:0];
            lsbb_pkg::REG_STRAIGHT_POWER:
               cfg_in.straight_power = csr_pwdata[lsbb_pkg::POWER_BITS-1:0];
            lsbb_pkg::REG_TURN_POWER:
               cfg_in.turn_power = csr_pwdata[lsbb_pkg::POWER_BITS-1:0];
            lsbb_pkg::REG_STOP_POWER:
               cfg_in.stop_power = csr_pwdata[lsbb_pkg::POWER_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold      <= lsbb_pkg::THRESHOLD_RESET;
         cfg_ff.straight_power <= lsbb_pkg::STRAIGHT_POWER_RESET;
         cfg_ff.turn_power     <= lsbb_pkg::TURN_POWER_RESET;
         cfg_ff.stop_power     <= lsbb_pkg::STOP_POWER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (index)
         lsbb_pkg::REG_THRESHOLD:
            csr_prdata = lsbb_pkg::CSR_DATA_BITS'(cfg_ff.threshold);
         lsbb_pkg::REG_STRAIGHT_POWER:
            csr_prdata = lsbb_pkg::CSR_DATA_BITS'(cfg_ff.straight_power);
         lsbb_pkg::REG_TURN_POWER:
            csr_prdata = lsbb_pkg::CSR_DATA_BITS'(cfg_ff.turn_power);
         lsbb_pkg::REG_STOP_POWER:
            csr_prdata = lsbb_pkg::CSR_DATA_BITS'(cfg_ff.stop_power);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/lsbb_cal.sv -----
// Calibration accumulators, sample counter and sensor baselines.
module lsbb_cal #(
   parameter int CAL_SAMPLES = lsbb_pkg::CAL_SAMPLES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  logic                               mode,
   input  logic [lsbb_pkg::SAMPLE_BITS-1:0]   left,
   input  logic [lsbb_pkg::SAMPLE_BITS-1:0]   right,
   output lsbb_pkg::baseline_type             baseline,
   output logic                               done
);

   localparam int CountBits = $clog2(CAL_SAMPLES + 1);
   // Reciprocal multiply: exact floor(sum / CAL_SAMPLES) for any sum below 2^SUM_BITS
   localparam int DivShift = lsbb_pkg::SUM_BITS + CountBits;
   localparam int MagicBits = DivShift + 1;
   localparam longint DivMagic =
      ((64'd1 << DivShift) + longint'(CAL_SAMPLES) - 64'd1) / longint'(CAL_SAMPLES);
   localparam int ProdBits = lsbb_pkg::SUM_BITS + MagicBits;

   logic [lsbb_pkg::SUM_BITS-1:0] sum_left_ff, sum_left_in, sum_right_ff, sum_right_in;
   logic [lsbb_pkg::SUM_BITS-1:0] sum_left_nxt, sum_right_nxt;
   logic [CountBits-1:0]          count_ff, count_in, count_plus;
   lsbb_pkg::baseline_type        baseline_ff, baseline_in;
   logic [MagicBits-1:0]          magic;
   logic [ProdBits-1:0]           prod_left, prod_right;
   logic                          cal_fire;

   assign magic    = MagicBits'(DivMagic);
   assign cal_fire = fire & (mode == lsbb_pkg::MODE_CAL);

   // Accumulate and count
   assign sum_left_nxt  = sum_left_ff + lsbb_pkg::SUM_BITS'(left);
   assign sum_right_nxt = sum_right_ff + lsbb_pkg::SUM_BITS'(right);
   assign count_plus    = count_ff + CountBits'(1);
   assign done = (mode == lsbb_pkg::MODE_CAL) && (count_plus >= CountBits'(CAL_SAMPLES));

   // Average of the completed round
   assign prod_left  = ProdBits'(sum_left_nxt) * ProdBits'(magic);
   assign prod_right = ProdBits'(sum_right_nxt) * ProdBits'(magic);

   always_comb begin
      sum_left_in  = sum_left_ff;
      sum_right_in = sum_right_ff;
      count_in     = count_ff;
      baseline_in  = baseline_ff;
      if (cal_fire) begin
         if (done) begin
            sum_left_in        = '0;
            sum_right_in       = '0;
            count_in           = '0;
            baseline_in.left   = prod_left[DivShift +: lsbb_pkg::SAMPLE_BITS];
            baseline_in.right  = prod_right[DivShift +: lsbb_pkg::SAMPLE_BITS];
         end else begin
            sum_left_in  = sum_left_nxt;
            sum_right_in = sum_right_nxt;
            count_in     = count_plus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_left_ff  <= '0;
         sum_right_ff <= '0;
         count_ff     <= '0;
         baseline_ff  <= '0;
      end else begin
         sum_left_ff  <= sum_left_in;
         sum_right_ff <= sum_right_in;
         count_ff     <= count_in;
         baseline_ff  <= baseline_in;
      end
   end

   assign baseline = baseline_ff;

endmodule

// ----- hdl/lsbb_run.sv -----
// Run mode: normalized difference, smoothing filter and bang-bang steering.
module lsbb_run (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      fire,
   input  logic                                      mode,
   input  logic [lsbb_pkg::SAMPLE_BITS-1:0]          left,
   input  logic [lsbb_pkg::SAMPLE_BITS-1:0]          right,
   input  lsbb_pkg::baseline_type                    baseline,
   input  lsbb_pkg::cfg_type                         cfg,
   output logic [lsbb_pkg::POWER_BITS-1:0]           left_power,
   output logic [lsbb_pkg::POWER_BITS-1:0]           right_power,
   output logic signed [lsbb_pkg::DIFF_BITS-1:0]     difference,
   output logic signed [lsbb_pkg::DIFF_BITS-1:0]     smoothed_difference
);

   localparam int NumBits  = lsbb_pkg::SMOOTH_MAG_BITS + 1;
   localparam int CmpBits  = lsbb_pkg::DIFF_BITS + 1;
   localparam int ProdBits = lsbb_pkg::SMOOTH_MAG_BITS + lsbb_pkg::SMOOTH_MAGIC_BITS;

   logic signed [lsbb_pkg::DIFF_BITS-1:0]   smooth_ff, smooth_in, smooth_new, diff;
   logic signed [NumBits-1:0]               num;
   logic [lsbb_pkg::SMOOTH_MAG_BITS-1:0]    num_mag;
   logic [ProdBits-1:0]                     prod;
   logic [lsbb_pkg::DIFF_BITS-1:0]          quot;
   logic signed [CmpBits-1:0]               diff_x, thr_pos, thr_neg;
   logic                                    is_run;

   assign is_run = (mode == lsbb_pkg::MODE_RUN);

   // (left - base_left) - (right - base_right)
   assign diff = $signed(lsbb_pkg::DIFF_BITS'(left)) - $signed(lsbb_pkg::DIFF_BITS'(baseline.left))
               - $signed(lsbb_pkg::DIFF_BITS'(right))
               + $signed(lsbb_pkg::DIFF_BITS'(baseline.right));

   // (3*old + 2*new) / 5 toward zero, via magnitude and reciprocal multiply
   assign num = NumBits'(smooth_ff) * $signed(NumBits'(3)) + NumBits'(diff) * $signed(NumBits'(2));
   assign num_mag = num[NumBits-1] ? lsbb_pkg::SMOOTH_MAG_BITS'(-num)
                                   : lsbb_pkg::SMOOTH_MAG_BITS'(num);
   assign prod = ProdBits'(num_mag) * ProdBits'(lsbb_pkg::SMOOTH_MAGIC);
   assign quot = lsbb_pkg::DIFF_BITS'(prod >> lsbb_pkg::SMOOTH_SHIFT);
   assign smooth_new = num[NumBits-1] ? -$signed(quot) : $signed(quot);

   assign smooth_in = (fire && is_run) ? smooth_new : smooth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
      end else begin
         smooth_ff <= smooth_in;
      end
   end

   // Dead band compare
   assign diff_x  = CmpBits'(diff);
   assign thr_pos = $signed(CmpBits'(cfg.threshold));
   assign thr_neg = -thr_pos;

   always_comb begin
      left_power  = '0;
      right_power = '0;
      if (is_run) begin
         priority if (diff_x < thr_neg) begin
            left_power  = cfg.stop_power;
            right_power = cfg.turn_power;
         end else if (diff_x > thr_pos) begin
            left_power  = cfg.turn_power;
            right_power = cfg.stop_power;
         end else begin
            left_power  = cfg.straight_power;
            right_power = cfg.straight_power;
         end
      end
   end

   assign difference          = is_run ? diff : '0;
   assign smoothed_difference = is_run ? smooth_new : smooth_ff;

endmodule

// ----- test/line_sensor_bang_bang_steering_tb.sv -----
// Self-checking stream testbench for the line sensor bang-bang steering block.
`timescale 1ns / 1ps

module line_sensor_bang_bang_steering_tb;
   import lsbb_pkg::*;

   localparam int CLOCK_PERIOD   = 12;
   localparam int CAL_ROUND      = CAL_SAMPLES_DEFAULT;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DIRECTED_ROWS  = 17;
   localparam int PHASE_COUNT    = 6;

   // One sensor request: kind, left sample, right sample
   typedef struct packed {
      logic                   kind;
      logic [SAMPLE_BITS-1:0] left;
      logic [SAMPLE_BITS-1:0] right;
   } sensor_request_t;

   // One steering response
   typedef struct packed {
      logic [POWER_BITS-1:0]        left_power;
      logic [POWER_BITS-1:0]        right_power;
      logic signed [DIFF_BITS-1:0]  difference;
      logic signed [DIFF_BITS-1:0]  smoothed;
      logic                         cal_done;
   } steer_result_t;

   // Request as offered, with an optional hand-typed response
   typedef struct packed {
      sensor_request_t rq;
      logic            typed;
      steer_result_t   want;
   } offered_request_t;

   // Settings of one random phase
   typedef struct {
      logic [THRESH_BITS-1:0] threshold;
      logic [POWER_BITS-1:0]  straight_power;
      logic [POWER_BITS-1:0]  turn_power;
      logic [POWER_BITS-1:0]  stop_power;
      int                     send_idle;
      int                     recv_stall;
      bit                     holdoff;
      int                     cal_lo;
      int                     cal_hi;
      int                     items;
   } phase_setup_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [23:0]              req_tdata = '0;  // left_sample, right_sample, pad
   logic                     req_tuser = 1'b0; // req_type
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [39:0]              rsp_tdata;  // left_power, right_power, difference, smoothed
   logic                     rsp_tuser;  // calibration_done
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   line_sensor_bang_bang_steering dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Predictor copy of the block's registers and state
   cfg_type                steer_cfg = '{THRESHOLD_RESET, STRAIGHT_POWER_RESET,
                                         TURN_POWER_RESET, STOP_POWER_RESET};
   logic [SUM_BITS-1:0]    cal_sum_left = '0;
   logic [SUM_BITS-1:0]    cal_sum_right = '0;
   logic [7:0]             cal_count = '0;
   logic [SAMPLE_BITS-1:0] base_left = '0;
   logic [SAMPLE_BITS-1:0] base_right = '0;
   int                     smooth_state = 0;

   steer_result_t    steering_expect_q[$];
   offered_request_t offered_q[$];
   int               mismatch_count = 0;

   // Idling controls for sender and receiver
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int holdoff_requests = 0;
   int holdoff_served = 0;
   int holdoff_left = 0;

   // Directed rows; smoothed values in typed rows follow from a zero start
   offered_request_t directed_rows [DIRECTED_ROWS] = '{
      '{'{MODE_RUN, 10'd0,    10'd0},    1'b1, '{8'd60, 8'd60, 12'sd0, 12'sd0, 1'b0}},
      '{'{MODE_RUN, 10'd1023, 10'd0},    1'b1, '{8'd80, 8'd0, 12'sd1023, 12'sd409, 1'b0}},
      '{'{MODE_RUN, 10'd0,    10'd1023}, 1'b1,
        '{8'd0, 8'd80, -12'sd1023, -12'sd163, 1'b0}},
      // dead band edges
      '{'{MODE_RUN, 10'd10,   10'd0},    1'b0, '0},
      '{'{MODE_RUN, 10'd11,   10'd0},    1'b0, '0},
      '{'{MODE_RUN, 10'd0,    10'd10},   1'b0, '0},
      '{'{MODE_RUN, 10'd0,    10'd11},   1'b0, '0},
      '{'{MODE_RUN, 10'd682,  10'd341},  1'b0, '0},
      '{'{MODE_RUN, 10'd341,  10'd682},  1'b0, '0},
      // partial calibration, interrupted by a run request
      '{'{MODE_CAL, 10'd1023, 10'd1023}, 1'b0, '0},
      '{'{MODE_CAL, 10'd0,    10'd0},    1'b0, '0},
      '{'{MODE_CAL, 10'd682,  10'd341},  1'b0, '0},
      '{'{MODE_CAL, 10'd341,  10'd682},  1'b0, '0},
      '{'{MODE_RUN, 10'd512,  10'd512},  1'b0, '0},
      '{'{MODE_CAL, 10'd1023, 10'd0},    1'b0, '0},
      '{'{MODE_CAL, 10'd0,    10'd1023}, 1'b0, '0},
      '{'{MODE_RUN, 10'd1023, 10'd1023}, 1'b0, '0}
   };

   phase_setup_t phase_plan [PHASE_COUNT] = '{
      '{11'd0,    8'd255, 8'd0,   8'd255, 0,  0,  1'b0, 0,    1023, 175},
      '{11'd2047, 8'd1,   8'd254, 8'd128, 60, 0,  1'b0, 900,  1023, 175},
      '{11'd40,   8'd60,  8'd200, 8'd10,  0,  60, 1'b1, 0,    200,  175},
      '{11'd300,  8'd0,   8'd255, 8'd0,   26, 26, 1'b0, 400,  600,  175},
      '{11'd2046, 8'd100, 8'd150, 8'd50,  0,  0,  1'b0, 1023, 1023, 175},
      '{11'd10,   8'd170, 8'd85,  8'd255, 26, 26, 1'b0, 0,    1023, 175}
   };

   // Advance the predictor by one request and return the response it implies
   function automatic steer_result_t predict_steering(sensor_request_t rq);
      steer_result_t res;
      int            diff;
      int            thr;
      res = '0;
      if (rq.kind == MODE_CAL) begin
         cal_sum_left  = cal_sum_left + SUM_BITS'(rq.left);
         cal_sum_right = cal_sum_right + SUM_BITS'(rq.right);
         cal_count     = cal_count + 8'd1;
         if (int'(cal_count) >= CAL_ROUND) begin
            base_left     = SAMPLE_BITS'(cal_sum_left / SUM_BITS'(CAL_ROUND));
            base_right    = SAMPLE_BITS'(cal_sum_right / SUM_BITS'(CAL_ROUND));
            cal_sum_left  = '0;
            cal_sum_right = '0;
            cal_count     = '0;
            res.cal_done  = 1'b1;
         end
      end else begin
         diff = (int'(rq.left) - int'(base_left)) - (int'(rq.right) - int'(base_right));
         thr  = int'(steer_cfg.threshold);
         // division truncates toward zero, as the block does
         smooth_state = (smooth_state * 3 + diff * 2) / 5;
         if (diff < -thr) begin
            res.left_power  = steer_cfg.stop_power;
            res.right_power = steer_cfg.turn_power;
         end else if (diff > thr) begin
            res.left_power  = steer_cfg.turn_power;
            res.right_power = steer_cfg.stop_power;
         end else begin
            res.left_power  = steer_cfg.straight_power;
            res.right_power = steer_cfg.straight_power;
         end
         res.difference = DIFF_BITS'(diff);
      end
      res.smoothed = DIFF_BITS'(smooth_state);
      return res;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] clamp_sample(int v);
      if (v < 0) return '0;
      if (v > 1023) return 10'd1023;
      return SAMPLE_BITS'(v);
   endfunction

   task automatic report_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Response check first, then bookkeeping for the accepted request
   always @(posedge clock) begin
      steer_result_t    got;
      steer_result_t    want;
      offered_request_t offered;
      steer_result_t    predicted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.left_power  = rsp_tdata[7:0];
            got.right_power = rsp_tdata[15:8];
            got.difference  = rsp_tdata[27:16];
            got.smoothed    = rsp_tdata[39:28];
            got.cal_done    = rsp_tuser;
            if (steering_expect_q.size() == 0) begin
               $display("%0t: response with nothing expected, actual %h / %b",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = steering_expect_q.pop_front();
               report_field("left_power", int'(want.left_power), int'(got.left_power));
               report_field("right_power", int'(want.right_power), int'(got.right_power));
               report_field("difference", int'(want.difference), int'(got.difference));
               report_field("smoothed_difference", int'(want.smoothed), int'(got.smoothed));
               report_field("calibration_done", int'(want.cal_done), int'(got.cal_done));
            end
         end
         if (req_tvalid && req_tready) begin
            offered   = offered_q.pop_front();
            predicted = predict_steering(offered.rq);
            steering_expect_q.push_back(offered.typed ? offered.want : predicted);
         end
      end
   end

   // Response side: random stalls, plus a long hold-off when one is requested
   always @(posedge clock) begin
      if (holdoff_served != holdoff_requests) begin
         holdoff_served <= holdoff_served + 1;
         holdoff_left   <= HOLDOFF_CYCLES;
         rsp_tready     <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Offer one request, with a random gap first, and wait for its acceptance
   task automatic offer_request(offered_request_t item);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= item.rq.kind;
      req_tdata  <= {4'b0, item.rq.right, item.rq.left};
      offered_q.push_back(item);
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every expected response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (steering_expect_q.size() != 0 || offered_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write followed by a read-back of the same register
   task automatic write_register(reg_index_type idx, logic [CSR_DATA_BITS-1:0] data,
                                 int width);
      logic [CSR_DATA_BITS-1:0] kept;
      kept = data & ((32'd1 << width) - 32'd1);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      // upper bits carry garbage that the register must drop
      csr_pwdata  <= data | ($urandom() << width);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_THRESHOLD:      steer_cfg.threshold      = THRESH_BITS'(kept);
         REG_STRAIGHT_POWER: steer_cfg.straight_power = POWER_BITS'(kept);
         REG_TURN_POWER:     steer_cfg.turn_power     = POWER_BITS'(kept);
         REG_STOP_POWER:     steer_cfg.stop_power     = POWER_BITS'(kept);
         default: ;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata != kept) begin
         $display("%0t: register %s read-back, expected %0d, actual %0d",
                  $time, idx.name(), kept, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Random phase: runs of calibration and run requests with random content
   task automatic run_phase(phase_setup_t ph);
      offered_request_t item;
      logic             cal_mode;
      int               span;
      cal_mode = $urandom_range(0, 1) != 0;
      for (int n = 0; n < ph.items; n++) begin
         if ($urandom_range(0, 99) < 5) cal_mode = !cal_mode;
         item = '0;
         span = (int'(steer_cfg.threshold) > 1000 ? 1000 : int'(steer_cfg.threshold)) + 8;
         if (cal_mode) begin
            item.rq.kind  = MODE_CAL;
            item.rq.left  = SAMPLE_BITS'($urandom_range(ph.cal_lo, ph.cal_hi));
            item.rq.right = SAMPLE_BITS'($urandom_range(ph.cal_lo, ph.cal_hi));
         end else if ($urandom_range(0, 3) == 0) begin
            item.rq.kind  = MODE_RUN;
            item.rq.left  = SAMPLE_BITS'($urandom_range(0, 1023));
            item.rq.right = SAMPLE_BITS'($urandom_range(0, 1023));
         end else begin
            // run samples near the baselines so the dead band edges get exercised
            item.rq.kind  = MODE_RUN;
            item.rq.left  = clamp_sample(int'(base_left) + $urandom_range(0, 2 * span) - span);
            item.rq.right = clamp_sample(int'(base_right) + $urandom_range(0, 2 * span) - span);
         end
         offer_request(item);
      end
   endtask

   // Main sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) offer_request(directed_rows[i]);
      drain_responses();

      foreach (phase_plan[p]) begin
         write_register(REG_THRESHOLD, 32'(phase_plan[p].threshold), THRESH_BITS);
         write_register(REG_STRAIGHT_POWER, 32'(phase_plan[p].straight_power), POWER_BITS);
         write_register(REG_TURN_POWER, 32'(phase_plan[p].turn_power), POWER_BITS);
         write_register(REG_STOP_POWER, 32'(phase_plan[p].stop_power), POWER_BITS);
         send_idle_pct  = phase_plan[p].send_idle;
         recv_stall_pct = phase_plan[p].recv_stall;
         if (phase_plan[p].holdoff) holdoff_requests <= holdoff_requests + 1;
         run_phase(phase_plan[p]);
         drain_responses();
      end

      if (mismatch_count == 0) begin
         $display("line_sensor_bang_bang_steering_tb: done, clean");
      end else begin
         $display("line_sensor_bang_bang_steering_tb: done, errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(CLOCK_PERIOD * 200000);
      $display("line_sensor_bang_bang_steering_tb: done, errors");
      $finish;
   end

endmodule
